// ===== design/totp_code_generator_defines.svh =====
// Assertion macros for the TOTP code generator.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef TOTP_CODE_GENERATOR_DEFINES_SVH
`define TOTP_CODE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TOTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TOTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/totp_pkg.sv =====
// Shared types, constants and helpers for the TOTP code generator.
// No dependencies.
`default_nettype none
package totp_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [4:0][31:0]  digest_t;   // index 0 is H0
  typedef logic [15:0][31:0] block_t;    // index 0 is W0

  localparam logic [7:0] REG_KEY_LOW  = 8'd0;
  localparam logic [7:0] REG_KEY_HIGH = 8'd1;
  localparam logic [7:0] REG_PERIOD   = 8'd2;
  localparam logic [7:0] REG_DIGITS   = 8'd3;

  localparam logic [11:0] PERIOD_RST = 12'd30;
  localparam logic [3:0]  DIGITS_RST = 4'd6;

  localparam word_t IPAD_WORD = 32'h3636_3636;
  localparam word_t OPAD_WORD = 32'h5C5C_5C5C;
  localparam word_t PAD_WORD  = 32'h8000_0000;
  localparam word_t LEN_INNER = 32'd576;   // 72 bytes
  localparam word_t LEN_OUTER = 32'd672;   // 84 bytes

  localparam digest_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_T, ST_HSTART, ST_HWAIT, ST_TRUNC, ST_DIV_M, ST_DONE
  } state_e;

  // 10^digits, saturated at nine digits
  function automatic logic [29:0] pow10(input logic [3:0] nd);
    logic [29:0] r;
    unique case (nd)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/totp_if.sv =====
// Valid/ready channel interfaces for the TOTP code generator.
// No dependencies.
`default_nettype none
interface totp_in_if;
  logic        valid;
  logic        ready;
  logic [39:0] unix_seconds;
  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface totp_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] otp_value;
  logic [11:0] seconds_left;
  modport source (output valid, output otp_value, output seconds_left, input ready);
  modport sink   (input valid, input otp_value, input seconds_left, output ready);
endinterface

interface totp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/totp_code_generator.sv =====
// Top level of the TOTP code generator: sequencer, config registers, output register.
// Depends on totp_pkg, totp_if, totp_div, totp_sha1 and the defines header.
`default_nettype none
`include "totp_code_generator_defines.svh"

// TOTP (HMAC-SHA1, time-step counter) code generator. One beat on in_i
// carries a Unix time; one beat on out_o returns the code reduced modulo
// 10^digits and the seconds left in the current period. The block handles
// one time value at a time: in_i.ready is high only while idle. An item
// passes through the time/period divide, four SHA-1 compressions of 80
// rounds each through one round unit (inner key block, counter block, outer
// key block, inner digest block), a truncation step, the modulo-10^digits
// divide, which reuses the same bit-serial divider, and the load of the
// output register. A new item is accepted only after the previous one has
// been loaded into the output register. A finished result sits in the output
// register until taken; the next item may be accepted meanwhile. Config writes
// (index 0 key low, 1 key high, 2 period, 3 digits) are always accepted and
// are meant to happen while idle. Period zero acts as one second; digits
// above nine saturate at nine.
module totp_code_generator import totp_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  totp_in_if.sink   in_i,
  totp_out_if.source out_o,
  totp_cfg_if.sink  cfg_i
);
  state_e      state_q, state_d;
  logic [1:0]  phase_q;
  logic [63:0] key_low_q;
  logic [15:0] key_high_q;
  logic [11:0] period_q;
  logic [3:0]  digits_q;
  logic [39:0] ctr_q;
  logic [11:0] secs_q;
  digest_t     chain_q, inner_q;
  logic [29:0] otp_q;
  logic        out_valid_q;
  logic [29:0] out_otp_q;
  logic [11:0] out_secs_q;

  logic        div_start, div_busy, div_done;
  logic [39:0] div_dividend, div_quo;
  logic [29:0] div_divisor, div_rem;
  logic        sha_start, sha_busy, sha_done;
  digest_t     sha_h, sha_digest;
  block_t      sha_block, key_blk;
  logic [11:0] per_eff;
  logic [159:0] mac;
  logic [159:0] mac_sh;
  logic [7:0]  sh_amt;
  logic [30:0] trunc_val;
  logic        out_load;
  word_t       pad;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign per_eff     = (period_q == 12'd0) ? 12'd1 : period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      period_q   <= PERIOD_RST;
      digits_q   <= DIGITS_RST;
    end else if (cfg_i.valid) begin
      priority case (cfg_i.index)
        REG_KEY_LOW:  key_low_q  <= cfg_i.data;
        REG_KEY_HIGH: key_high_q <= cfg_i.data[15:0];
        REG_PERIOD:   period_q   <= cfg_i.data[11:0];
        REG_DIGITS:   digits_q   <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  // Message block for the current compression
  always_comb begin
    pad     = phase_q[1] ? OPAD_WORD : IPAD_WORD;
    key_blk = '0;
    key_blk[0] = {key_high_q, key_low_q[63:48]};
    key_blk[1] = key_low_q[47:16];
    key_blk[2] = {key_low_q[15:0], 16'h0000};
    for (int j = 0; j < 16; j++) key_blk[j] = key_blk[j] ^ pad;
    sha_block = '0;
    sha_h     = SHA1_IV;
    unique case (phase_q)
      2'd0, 2'd2: sha_block = key_blk;
      2'd1: begin
        sha_h        = chain_q;
        sha_block[0] = {24'h0, ctr_q[39:32]};
        sha_block[1] = ctr_q[31:0];
        sha_block[2] = PAD_WORD;
        sha_block[15] = LEN_INNER;
      end
      default: begin
        sha_h        = chain_q;
        for (int j = 0; j < 5; j++) sha_block[j] = inner_q[j];
        sha_block[5]  = PAD_WORD;
        sha_block[15] = LEN_OUTER;
      end
    endcase
  end

  // Dynamic truncation: low nibble of the last byte picks four bytes
  always_comb begin
    mac       = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
    sh_amt    = 8'd128 - {1'b0, mac[3:0], 3'b000};
    mac_sh    = mac >> sh_amt;
    trunc_val = mac_sh[30:0];
  end

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = {9'h000, trunc_val};
    div_divisor  = pow10(digits_q);
    sha_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) begin
        div_start    = 1'b1;
        div_dividend = in_i.unix_seconds;
        div_divisor  = {18'h0, per_eff};
        state_d      = ST_DIV_T;
      end
      ST_DIV_T:   if (div_done) state_d = ST_HSTART;
      ST_HSTART: begin
        sha_start = 1'b1;
        state_d   = ST_HWAIT;
      end
      ST_HWAIT: if (sha_done) state_d = (phase_q == 2'd3) ? ST_TRUNC : ST_HSTART;
      ST_TRUNC: begin
        div_start = 1'b1;
        state_d   = ST_DIV_M;
      end
      ST_DIV_M:   if (div_done) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_o.ready) begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) phase_q <= '0;
      else if (state_q == ST_HWAIT && sha_done) phase_q <= phase_q + 2'd1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_T && div_done) begin
      ctr_q  <= div_quo;
      secs_q <= per_eff - div_rem[11:0];
    end
    if (state_q == ST_HWAIT && sha_done) begin
      chain_q <= sha_digest;
      if (phase_q == 2'd1) inner_q <= sha_digest;
    end
    if (state_q == ST_DIV_M && div_done) otp_q <= div_rem;
    if (out_load) begin
      out_otp_q  <= otp_q;
      out_secs_q <= secs_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.otp_value    = out_otp_q;
  assign out_o.seconds_left = out_secs_q;

  totp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  totp_sha1 u_sha1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sha_start),
    .h_i      (sha_h),
    .block_i  (sha_block),
    .busy_o   (sha_busy),
    .done_o   (sha_done),
    .digest_o (sha_digest)
  );

  `TOTP_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, state_q == ST_DIV_T, "not busy after accept")
  `TOTP_ASSERT_IMP(a_units_exclusive, div_busy, !sha_busy, "divider and hash overlap")
  `TOTP_ASSERT_IMP(a_secs_nonzero, out_valid_q, out_secs_q != 12'd0, "seconds_left zero")
  `TOTP_ASSERT_IMP(a_sha_start_idle, sha_start, !sha_busy && !div_busy, "hash start while busy")
endmodule
`default_nettype wire

// ===== design/totp_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// No package dependencies.
`default_nettype none
module totp_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [39:0] dividend_i,
  input  wire logic [29:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [39:0]      quotient_o,
  output logic [29:0]      remainder_o
);
  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [39:0] quo_q, quo_d;
  logic [29:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [30:0] trial, diff;

  always_comb begin
    trial  = {rem_q, quo_q[39]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[30]) begin
        rem_d = diff[29:0];
        quo_d = {quo_q[38:0], 1'b1};
      end else begin
        rem_d = trial[29:0];
        quo_d = {quo_q[38:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd39) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
endmodule
`default_nettype wire

// ===== design/totp_sha1.sv =====
// SHA-1 compression, one round per cycle (80 rounds plus final add).
// Depends on totp_pkg.
`default_nettype none
module totp_sha1 import totp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire digest_t h_i,
  input  wire block_t  block_i,
  output logic         busy_o,
  output logic         done_o,
  output digest_t      digest_o
);
  logic    busy_q, done_q;
  logic [6:0] round_q;
  word_t   a_q, b_q, c_q, d_q, e_q;
  digest_t h_q;
  word_t   w_q [16];
  word_t   f, k, t, wn;

  always_comb begin
    if (round_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = 32'h5A827999;
    end else if (round_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = 32'h6ED9EBA1;
    end else if (round_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = 32'hCA62C1D6;
    end
    t  = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    wn = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        round_q <= '0;
      end else if (busy_q) begin
        round_q <= round_q + 7'd1;
        if (round_q == 7'd79) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q <= h_i;
      a_q <= h_i[0];
      b_q <= h_i[1];
      c_q <= h_i[2];
      d_q <= h_i[3];
      e_q <= h_i[4];
      for (int j = 0; j < 16; j++) w_q[j] <= block_i[j];
    end else if (busy_q) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
      w_q[15] <= {wn[30:0], wn[31]};
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign digest_o[0] = h_q[0] + a_q;
  assign digest_o[1] = h_q[1] + b_q;
  assign digest_o[2] = h_q[2] + c_q;
  assign digest_o[3] = h_q[3] + d_q;
  assign digest_o[4] = h_q[4] + e_q;
endmodule
`default_nettype wire

// ===== tb/totp_code_generator_checker.sv =====
// Result checker for the TOTP code generator: watches the key/period/digits writes,
// predicts each code with its own HMAC-SHA1 and compares the result beats in order.
// Depends on totp_pkg and the channel interfaces in totp_if.
`default_nettype none
module totp_code_generator_checker import totp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  totp_in_if        in_m,
  totp_out_if       out_m,
  totp_cfg_if       cfg_m,
  output int        fail_count_o,
  output int        codes_pending_o,
  output int        codes_checked_o
);

  typedef struct packed {
    logic [29:0] otp_value;
    logic [11:0] seconds_left;
  } totp_code_t;

  logic [63:0] key_lo_q;
  logic [15:0] key_hi_q;
  logic [11:0] period_q;
  logic [3:0]  digits_q;
  totp_code_t  code_q[$];

  function automatic digest_t sha1_compress(input digest_t h, input block_t m);
    word_t w[80];
    word_t a, b, c, d, e, f, k, t;
    digest_t r;
    for (int i = 0; i < 16; i++) w[i] = m[i];
    for (int i = 16; i < 80; i++) begin
      t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {t[30:0], t[31]};
    end
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    r[0] = h[0] + a; r[1] = h[1] + b; r[2] = h[2] + c; r[3] = h[3] + d; r[4] = h[4] + e;
    return r;
  endfunction

  function automatic totp_code_t predict_code(input logic [39:0] secs);
    block_t  key_blk, blk;
    digest_t inner, mac;
    logic [63:0]  step;
    logic [11:0]  per;
    logic [159:0] mac_bits;
    logic [31:0]  val, modulus;
    int           off;
    totp_code_t   r;
    per  = (period_q == '0) ? 12'd1 : period_q;
    step = 64'(secs / per);
    key_blk = '0;
    key_blk[0] = {key_hi_q, key_lo_q[63:48]};
    key_blk[1] = key_lo_q[47:16];
    key_blk[2] = {key_lo_q[15:0], 16'h0};
    // inner hash: ipad key block, then counter + padding
    for (int i = 0; i < 16; i++) blk[i] = key_blk[i] ^ IPAD_WORD;
    inner = sha1_compress(SHA1_IV, blk);
    blk = '0;
    blk[0] = step[63:32]; blk[1] = step[31:0]; blk[2] = PAD_WORD; blk[15] = LEN_INNER;
    inner = sha1_compress(inner, blk);
    // outer hash: opad key block, then inner digest + padding
    for (int i = 0; i < 16; i++) blk[i] = key_blk[i] ^ OPAD_WORD;
    mac = sha1_compress(SHA1_IV, blk);
    blk = '0;
    for (int i = 0; i < 5; i++) blk[i] = inner[i];
    blk[5] = PAD_WORD; blk[15] = LEN_OUTER;
    mac = sha1_compress(mac, blk);
    mac_bits = {mac[0], mac[1], mac[2], mac[3], mac[4]};
    off = mac_bits[3:0];
    val = mac_bits[159 - 8*off -: 32] & 32'h7FFF_FFFF;
    modulus = 1;
    for (int i = 0; i < ((digits_q > 9) ? 9 : digits_q); i++) modulus = modulus * 10;
    r.otp_value    = 30'(val % modulus);
    r.seconds_left = 12'(per - 12'(secs % per));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    totp_code_t exp_c;
    int         errs;
    errs = 0;
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      period_q <= PERIOD_RST;
      digits_q <= DIGITS_RST;
      code_q.delete();
      fail_count_o    <= 0;
      codes_checked_o <= 0;
    end else begin
      if (cfg_m.valid && cfg_m.ready) begin
        case (cfg_m.index)
          REG_KEY_LOW:  key_lo_q <= cfg_m.data;
          REG_KEY_HIGH: key_hi_q <= cfg_m.data[15:0];
          REG_PERIOD:   period_q <= cfg_m.data[11:0];
          REG_DIGITS:   digits_q <= cfg_m.data[3:0];
          default: ;
        endcase
      end
      if (in_m.valid && in_m.ready) code_q.push_back(predict_code(in_m.unix_seconds));
      if (out_m.valid && out_m.ready) begin
        if (code_q.size() == 0) begin
          $error("result beat with no code expected: otp_value %0d seconds_left %0d",
                 out_m.otp_value, out_m.seconds_left);
          errs++;
        end else begin
          exp_c = code_q.pop_front();
          codes_checked_o <= codes_checked_o + 1;
          if (exp_c.otp_value !== out_m.otp_value) begin
            $error("otp_value mismatch: expected %0d, got %0d",
                   exp_c.otp_value, out_m.otp_value);
            errs++;
          end
          if (exp_c.seconds_left !== out_m.seconds_left) begin
            $error("seconds_left mismatch: expected %0d, got %0d",
                   exp_c.seconds_left, out_m.seconds_left);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

  assign codes_pending_o = code_q.size();

endmodule
`default_nettype wire

// ===== tb/totp_code_generator_test.sv =====
// Testbench top for the TOTP code generator: clock, reset, time/config stimulus,
// result back-pressure, watchdog and verdict. Checking lives in totp_code_generator_checker.
// Depends on totp_pkg, totp_if, the block and the checker.
`default_nettype none
module totp_code_generator_test;
  import totp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;  // one item's processing plus max gap and stall, with margin
  localparam int DRAIN_CYCLES   = 500;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int RAND_PHASES     = 11;

  logic clk_i;
  logic rst_ni;
  int   fail_count, codes_pending, codes_checked;
  int   items_sent;
  int   idle_cycles;
  bit   no_idle;       // phases that run back to back on both sides
  int   ready_wait;

  totp_in_if  in_ch();
  totp_out_if out_ch();
  totp_cfg_if cfg_ch();

  totp_code_generator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  totp_code_generator_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_m            (in_ch),
    .out_m           (out_ch),
    .cfg_m           (cfg_ch),
    .fail_count_o    (fail_count),
    .codes_pending_o (codes_pending),
    .codes_checked_o (codes_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: per beat draw a random stall, none in no-idle phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      ready_wait   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      ready_wait   <= no_idle ? 0 : $urandom_range(0, 18);
      out_ch.ready <= no_idle;
    end else if (ready_wait > 0) begin
      ready_wait   <= ready_wait - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: any accepted beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [63:0] klo, input logic [15:0] khi,
                            input logic [11:0] per, input logic [3:0] nd);
    write_reg(REG_KEY_LOW, klo);
    write_reg(REG_KEY_HIGH, {48'h0, khi});
    write_reg(REG_PERIOD, {52'h0, per});
    write_reg(REG_DIGITS, {60'h0, nd});
  endtask

  // One time beat; valid stays high across back-to-back beats.
  task automatic send_time(input logic [39:0] secs);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.unix_seconds <= secs;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Between phases: wait for every code to come back, then idle before touching registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (codes_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [39:0] rand_time(input logic [11:0] per);
    logic [39:0] t;
    case ($urandom_range(0, 3))
      0:       t = {$urandom, $urandom};                       // full 40-bit range
      1:       t = 40'($urandom_range(1_500_000_000, 2_200_000_000)); // present-day times
      2:       t = 40'($urandom_range(0, 5000));               // near the epoch
      default: begin                                           // on or just before a step boundary
        t = {$urandom, $urandom} >> $urandom_range(0, 30);
        if (per != 0) t = t - (t % per) - 40'($urandom_range(0, 1));
      end
    endcase
    return t;
  endfunction

  initial begin
    logic [11:0] per;
    logic [3:0]  nd;
    rst_ni             = 1'b0;
    no_idle            = 1'b0;
    items_sent         = 0;
    in_ch.valid        = 1'b0;
    in_ch.unix_seconds = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_KEY_LOW;
    cfg_ch.data        = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings (zero key, 30 s period, six digits), time extremes
    // and step edges, including the published test vector time.
    send_time(40'd0);
    send_time(40'd1);
    send_time(40'd29);
    send_time(40'd30);
    send_time(40'd59);
    send_time(40'd1_111_111_109);
    send_time(40'd2_000_000_000);
    send_time(40'hFF_FFFF_FFFF);
    drain();
    // Period zero acts as one second; digits zero gives a zero code.
    set_config(64'h3132_3334_3536_3738, 16'h3930, 12'd0, 4'd0);
    send_time(40'd59);
    send_time(40'hFF_FFFF_FFFF);
    drain();
    // Shortest legal period, one digit, zero key.
    set_config(64'h0, 16'h0, 12'd1, 4'd1);
    send_time(40'd0);
    send_time(40'hAA_AAAA_AAAA);
    send_time(40'h55_5555_5555);
    drain();
    // Longest legal period, nine digits, all-ones key.
    set_config('1, '1, 12'd3600, 4'd9);
    send_time(40'd3599);
    send_time(40'd3600);
    send_time(40'hFF_FFFF_FFFF);
    drain();
    // Period above range and digits above nine (saturate at nine).
    set_config(64'h0123_4567_89AB_CDEF, 16'hFEDC, 12'hFFF, 4'hF);
    send_time(40'd4094);
    send_time(40'd4095);
    send_time(40'hFF_FFFF_FFFF);
    drain();

    // Random phases: a fresh setting per phase, two with no idling at all.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 5)
        0:       per = 12'd30;
        1:       per = 12'($urandom_range(1, 3600));
        2:       per = 12'($urandom_range(1, 90));
        3:       per = 12'($urandom_range(0, 4095));
        default: per = 12'd60;
      endcase
      nd = (ph % 4 == 2) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 9));
      set_config({$urandom, $urandom}, 16'($urandom), per, nd);
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_time(rand_time(per));
      drain();
      no_idle = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d time beats over %0d register settings, %0d codes compared",
             items_sent, RAND_PHASES + 5, codes_checked);
    $display("settings included period 0/1/3600/4095, digits 0/1/9/15, zero and all-ones key");
    if (fail_count == 0 && codes_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/totp_pkg.sv
design/totp_if.sv
design/totp_div.sv
design/totp_sha1.sv
design/totp_code_generator.sv
tb/totp_code_generator_checker.sv
tb/totp_code_generator_test.sv
